// ----- rtl/bks_pkg.sv -----
// ----------------------------------------------------------------------------
// bks_pkg
// Shared constants for the box Kalman smoother: register map, reset values
// and field widths.
// ----------------------------------------------------------------------------
package bks_pkg;

  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;
  localparam int CFG_IW     = 3;
  localparam int OUT_LANES  = 4;
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 15;
  localparam int Z_W        = 17;

  localparam logic [CFG_IW-1:0] REG_PROCESS_NOISE = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MEASURE_NOISE = 3'd1;
  localparam logic [CFG_IW-1:0] REG_INIT_COV_X    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_INIT_COV_Y    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_INIT_COV_W    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_INIT_COV_H    = 3'd5;

  localparam logic [CFG_DW-1:0] PROCESS_NOISE_RST = 32'd13107200;
  localparam logic [CFG_DW-1:0] MEASURE_NOISE_RST = 32'd32768000;
  localparam logic [CFG_DW-1:0] INIT_COV_RST      = 32'd65536;

  localparam logic [1:0] LANE_X = 2'd0;
  localparam logic [1:0] LANE_Y = 2'd1;
  localparam logic [1:0] LANE_W = 2'd2;
  localparam logic [1:0] LANE_H = 2'd3;

endpackage

// ----- rtl/bks_cfg.sv -----
// ----------------------------------------------------------------------------
// bks_cfg
// APB register file: noise covariances and per-lane initial covariances.
// ----------------------------------------------------------------------------
module bks_cfg import bks_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_AW-1:0]            paddr,
  input  logic [CFG_DW-1:0]            pwdata,
  output logic [CFG_DW-1:0]            prdata,
  output logic                         pready,
  output logic [CFG_DW-1:0]            process_noise,
  output logic [CFG_DW-1:0]            measure_noise,
  output logic [OUT_LANES-1:0][CFG_DW-1:0] init_cov
);

  logic [CFG_DW-1:0]                 q_r, r_r;
  logic [OUT_LANES-1:0][CFG_DW-1:0]  cov_r;
  logic [CFG_IW-1:0]                 idx;
  logic                              wr;

  assign idx   = paddr[CFG_AW-1:2];
  assign wr    = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= PROCESS_NOISE_RST;
      r_r   <= MEASURE_NOISE_RST;
      cov_r <= {OUT_LANES{INIT_COV_RST}};
    end else if (wr) begin
      case (idx)
        REG_PROCESS_NOISE: q_r <= pwdata;
        REG_MEASURE_NOISE: r_r <= pwdata;
        REG_INIT_COV_X:    cov_r[LANE_X] <= pwdata;
        REG_INIT_COV_Y:    cov_r[LANE_Y] <= pwdata;
        REG_INIT_COV_W:    cov_r[LANE_W] <= pwdata;
        REG_INIT_COV_H:    cov_r[LANE_H] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROCESS_NOISE: prdata = q_r;
      REG_MEASURE_NOISE: prdata = r_r;
      REG_INIT_COV_X:    prdata = cov_r[LANE_X];
      REG_INIT_COV_Y:    prdata = cov_r[LANE_Y];
      REG_INIT_COV_W:    prdata = cov_r[LANE_W];
      REG_INIT_COV_H:    prdata = cov_r[LANE_H];
      default:           prdata = '0;
    endcase
  end

  assign process_noise = q_r;
  assign measure_noise = r_r;
  assign init_cov      = cov_r;

endmodule

// ----- rtl/bks_div.sv -----
// ----------------------------------------------------------------------------
// bks_div
// Restoring divider for the Kalman gain: floor(num * 2^F / den), one
// quotient bit per cycle, saturated to 2^F-1, zero for a zero denominator.
// ----------------------------------------------------------------------------
module bks_div import bks_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CFG_DW-1:0]    num,
  input  logic [CFG_DW:0]      den,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quo
);

  localparam int F  = FRAC_BITS;
  localparam int RW = CFG_DW + 2;
  localparam int CW = $clog2(F + 2);

  logic [RW-1:0]     rem_r;
  logic [CFG_DW:0]   den_r;
  logic [F:0]        quo_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r, zero_r;
  logic              ge;
  logic [RW-1:0]     sub, rsel;

  assign ge   = rem_r >= {1'b0, den_r};
  assign sub  = rem_r - {1'b0, den_r};
  assign rsel = ge ? sub : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(F + 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= RW'(num);
      den_r  <= den;
      zero_r <= (den == '0);
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= {rsel[RW-2:0], 1'b0};
      quo_r <= {quo_r[F-1:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = zero_r   ? '0 :
                quo_r[F] ? {F{1'b1}} : quo_r[F-1:0];

endmodule

// ----- rtl/bks_lane_mem.sv -----
// ----------------------------------------------------------------------------
// bks_lane_mem
// Lane state store: estimate and covariance memories with registered reads
// and per-entry valid bits so unwritten lanes read as zero.
// ----------------------------------------------------------------------------
module bks_lane_mem import bks_pkg::*; #(
  parameter int LANES = 4,
  parameter int EST_W = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_en,
  input  logic [(LANES > 1 ? $clog2(LANES) : 1)-1:0] rd_idx,
  input  logic                                 wr_en,
  input  logic [(LANES > 1 ? $clog2(LANES) : 1)-1:0] wr_idx,
  input  logic [EST_W-1:0]                     wr_est,
  input  logic [CFG_DW-1:0]                    wr_cov,
  output logic [EST_W-1:0]                     rd_est,
  output logic [CFG_DW-1:0]                    rd_cov
);

  logic [EST_W-1:0]  est_mem [LANES];
  logic [CFG_DW-1:0] cov_mem [LANES];
  logic [LANES-1:0]  valid_r;
  logic [EST_W-1:0]  est_q;
  logic [CFG_DW-1:0] cov_q;
  logic              vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      est_mem[wr_idx] <= wr_est;
      cov_mem[wr_idx] <= wr_cov;
    end
    if (rd_en) begin
      est_q <= est_mem[rd_idx];
      cov_q <= cov_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_idx] <= 1'b1;
      if (rd_en) vld_q <= valid_r[rd_idx];
    end
  end

  assign rd_est = vld_q ? est_q : '0;
  assign rd_cov = vld_q ? cov_q : '0;

endmodule

// ----- rtl/box_kalman_smoother_unit.sv -----
// ----------------------------------------------------------------------------
// box_kalman_smoother_unit
// Bounding-box smoother: four scalar Kalman lanes (x, y, width, height).
// ----------------------------------------------------------------------------
// Input channel (in_*): one beat per box. in_operation 0 starts a track from
// the rectangle, 1 runs one predict/correct step with the measured rectangle.
// Output channel (out_*): exactly one beat per input beat, in order.
// Configuration: APB registers for q, r and the four initial covariances;
// write them only while no beat is in flight.
// The lanes are processed one after another through a shared datapath that
// reads lane state from memory, modifies it and writes it back. Per lane, a
// start beat steps through READ, PRED and WB; an update beat through READ,
// PRED, DIVS, DIV (one quotient bit per cycle), MHI, MLO, MP, CORR and WB.
// The finished result sits in an output register, so a new beat is taken
// while a result is still stalled; completion of the next one then holds
// until the output register frees.
// Reset clears all lane estimates and covariances to zero and restores the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module box_kalman_smoother_unit import bks_pkg::*; #(
  parameter int LANES     = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic signed [COORD_W-1:0] in_rect_x,
  input  logic signed [COORD_W-1:0] in_rect_y,
  input  logic [SIZE_W-1:0]         in_rect_w,
  input  logic [SIZE_W-1:0]         in_rect_h,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_est_x,
  output logic signed [COORD_W-1:0] out_est_y,
  output logic [SIZE_W-1:0]         out_est_w,
  output logic [SIZE_W-1:0]         out_est_h,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_AW-1:0]         paddr,
  input  logic [CFG_DW-1:0]         pwdata,
  output logic [CFG_DW-1:0]         prdata,
  output logic                      pready
);

  localparam int F      = FRAC_BITS;
  localparam int EW     = 24 + F;
  localparam int DW     = 26 + F;
  localparam int MW     = 25 + F;
  localparam int IW     = MW - F;
  localparam int DLW    = 26 + F;
  localparam int XW     = 27 + F;
  localparam int PW     = CFG_DW + F + 1;
  localparam int LW     = LANES > 1 ? $clog2(LANES) : 1;
  localparam int ACTIVE = LANES < OUT_LANES ? LANES : OUT_LANES;
  localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_READ = 11'b000_0000_0010,
    S_PRED = 11'b000_0000_0100,
    S_DIVS = 11'b000_0000_1000,
    S_DIV  = 11'b000_0001_0000,
    S_MHI  = 11'b000_0010_0000,
    S_MLO  = 11'b000_0100_0000,
    S_MP   = 11'b000_1000_0000,
    S_CORR = 11'b001_0000_0000,
    S_WB   = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_DW-1:0]                 q_cfg, r_cfg;
  logic [OUT_LANES-1:0][CFG_DW-1:0]  cov_cfg;

  logic                      op_r;
  logic signed [COORD_W-1:0] rx_r, ry_r;
  logic [SIZE_W-1:0]         rw_r, rh_r;
  logic [LW-1:0]             lane_r, lane_nxt;
  logic [1:0]                lane2;
  logic                      last_lane;

  logic [EW-1:0]       lm_rd_est;
  logic [CFG_DW-1:0]   lm_rd_cov;
  logic                lm_rd_en, lm_wr_en;

  logic                div_start, div_done;
  logic [F-1:0]        div_quo;

  logic [CFG_DW-1:0]   p_r;
  logic [EW-1:0]       x_r, xn_r;
  logic [MW-1:0]       mag_r;
  logic                neg_r;
  logic [F-1:0]        gain_r;
  logic [PW-1:0]       prod_r;
  logic [IW+F-1:0]     hi_r;
  logic [DLW-1:0]      delta_r;
  logic [CFG_DW-1:0]   pn_r;
  logic [COORD_W-1:0]  res_r [OUT_LANES];

  logic                out_valid_r, out_load;
  logic [COORD_W-1:0]  ox_r, oy_r;
  logic [SIZE_W-1:0]   ow_r, oh_r;

  logic [Z_W-1:0]      z_sel;
  logic [EW-1:0]       z_fix;
  logic [CFG_DW-1:0]   init_sel;
  logic [CFG_DW:0]     p_sum;
  logic [CFG_DW-1:0]   p_sat;
  logic [DW-1:0]       diff, diff_abs;
  logic [CFG_DW-1:0]   mul_a;
  logic [F:0]          mul_b;
  logic [XW-1:0]       xs, xsum;
  logic                ovf_pos, ovf_neg;
  logic [EW-1:0]       xclamp;
  logic [EW:0]         ext, ax;
  logic [EW-F:0]       ival;
  logic                xneg;
  logic [COORD_W-1:0]  res_val;

  bks_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .process_noise (q_cfg),
    .measure_noise (r_cfg),
    .init_cov      (cov_cfg)
  );

  bks_lane_mem #(.LANES(LANES), .EST_W(EW)) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (lm_rd_en),
    .rd_idx (lane_r),
    .wr_en  (lm_wr_en),
    .wr_idx (lane_r),
    .wr_est (xn_r),
    .wr_cov (pn_r),
    .rd_est (lm_rd_est),
    .rd_cov (lm_rd_cov)
  );

  bks_div #(.FRAC_BITS(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (p_r),
    .den   ({1'b0, p_r} + {1'b0, r_cfg}),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign lane2     = 2'(lane_r);
  assign last_lane = (lane_r == LW'(ACTIVE - 1));
  assign lm_rd_en  = (state_r == S_READ);
  assign lm_wr_en  = (state_r == S_WB);
  assign div_start = (state_r == S_DIVS);
  assign in_stall  = (state_r != S_IDLE);
  assign out_load  = (state_r == S_DONE) && !(out_valid_r && out_stall);

  always_comb begin
    case (lane2)
      LANE_X:  begin z_sel = {rx_r[COORD_W-1], rx_r}; init_sel = cov_cfg[LANE_X]; end
      LANE_Y:  begin z_sel = {ry_r[COORD_W-1], ry_r}; init_sel = cov_cfg[LANE_Y]; end
      LANE_W:  begin z_sel = {2'b00, rw_r};           init_sel = cov_cfg[LANE_W]; end
      LANE_H:  begin z_sel = {2'b00, rh_r};           init_sel = cov_cfg[LANE_H]; end
      default: begin z_sel = '0;                      init_sel = '0; end
    endcase
  end

  assign z_fix    = {{(EW-Z_W-F){z_sel[Z_W-1]}}, z_sel, {F{1'b0}}};
  assign p_sum    = {1'b0, lm_rd_cov} + {1'b0, q_cfg};
  assign p_sat    = p_sum[CFG_DW] ? {CFG_DW{1'b1}} : p_sum[CFG_DW-1:0];
  assign diff     = {{(DW-EW){z_fix[EW-1]}}, z_fix} - {{(DW-EW){lm_rd_est[EW-1]}}, lm_rd_est};
  assign diff_abs = diff[DW-1] ? (DW'(0) - diff) : diff;

  always_comb begin
    case (state_r)
      S_MHI:   begin mul_a = CFG_DW'(mag_r[MW-1:F]); mul_b = {1'b0, gain_r};  end
      S_MLO:   begin mul_a = CFG_DW'(mag_r[F-1:0]);  mul_b = {1'b0, gain_r};  end
      S_MP:    begin mul_a = p_r;                    mul_b = ONE_Q - {1'b0, gain_r}; end
      default: begin mul_a = '0;                     mul_b = '0;              end
    endcase
  end

  assign xs      = {{(XW-EW){x_r[EW-1]}}, x_r};
  assign xsum    = neg_r ? (xs - XW'(delta_r)) : (xs + XW'(delta_r));
  assign ovf_pos = !xsum[XW-1] && (|xsum[XW-2:EW-1]);
  assign ovf_neg = xsum[XW-1] && !(&xsum[XW-2:EW-1]);
  assign xclamp  = ovf_pos ? {1'b0, {(EW-1){1'b1}}} :
                   ovf_neg ? {1'b1, {(EW-1){1'b0}}} : xsum[EW-1:0];

  assign xneg = xn_r[EW-1];
  assign ext  = {xn_r[EW-1], xn_r};
  assign ax   = xneg ? ((EW+1)'(0) - ext) : ext;
  assign ival = ax[EW:F];

  always_comb begin
    if (lane2 == LANE_X || lane2 == LANE_Y) begin
      if (!xneg)
        res_val = (ival > (EW-F+1)'(32767)) ? 16'h7FFF : ival[COORD_W-1:0];
      else
        res_val = (ival > (EW-F+1)'(32768)) ? 16'h8000 : (16'(0) - ival[COORD_W-1:0]);
    end else begin
      if (xneg)
        res_val = '0;
      else
        res_val = (ival > (EW-F+1)'(32767)) ? 16'h7FFF : {1'b0, ival[SIZE_W-1:0]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        state_nxt = S_READ;
        lane_nxt  = '0;
      end
      S_READ: state_nxt = S_PRED;
      S_PRED: state_nxt = op_r ? S_DIVS : S_WB;
      S_DIVS: state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_MHI;
      S_MHI:  state_nxt = S_MLO;
      S_MLO:  state_nxt = S_MP;
      S_MP:   state_nxt = S_CORR;
      S_CORR: state_nxt = S_WB;
      S_WB: begin
        if (last_lane) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
          lane_nxt  = lane_r + LW'(1);
        end
      end
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lane_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_r      <= lane_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
    case (state_r)
      S_IDLE: if (in_valid) begin
        op_r <= in_operation;
        rx_r <= in_rect_x;
        ry_r <= in_rect_y;
        rw_r <= in_rect_w;
        rh_r <= in_rect_h;
        for (int i = 0; i < OUT_LANES; i++) res_r[i] <= '0;
      end
      S_PRED: begin
        if (op_r) begin
          p_r   <= p_sat;
          x_r   <= lm_rd_est;
          mag_r <= diff_abs[MW-1:0];
          neg_r <= diff[DW-1];
        end else begin
          xn_r <= z_fix;
          pn_r <= init_sel;
        end
      end
      S_DIV: if (div_done) gain_r <= div_quo;
      S_MLO: hi_r <= prod_r[IW+F-1:0];
      S_MP:  delta_r <= DLW'(hi_r) + DLW'(prod_r[2*F-1:F]);
      S_CORR: begin
        pn_r <= prod_r[F+CFG_DW-1:F];
        xn_r <= xclamp;
      end
      S_WB: res_r[lane2] <= res_val;
      S_DONE: if (out_load) begin
        ox_r <= res_r[LANE_X];
        oy_r <= res_r[LANE_Y];
        ow_r <= res_r[LANE_W][SIZE_W-1:0];
        oh_r <= res_r[LANE_H][SIZE_W-1:0];
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_est_x = ox_r;
  assign out_est_y = oy_r;
  assign out_est_w = ow_r;
  assign out_est_h = oh_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the gain wait");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load did not raise valid and release input");

  a_lane_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB && !last_lane) |=>
      (state_r == S_READ && lane_r == $past(lane_r) + LW'(1)))
    else $error("lane sequencing broken after write-back");

endmodule

// ----- test/box_kalman_smoother_unit_tb.sv -----
// ----------------------------------------------------------------------------
// box_kalman_smoother_unit_tb
// Drives start and update boxes through the smoother under random idling on
// both channels. A built-in fixed-point predictor of the four Kalman lanes
// checks every output beat field by field. Noise and covariance registers
// are rewritten between phases over APB, including their extremes.
// ----------------------------------------------------------------------------
module box_kalman_smoother_unit_tb import bks_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     LANES       = 4;
  localparam int     FRAC        = 16;
  localparam longint ONE_Q       = longint'(1) <<< FRAC;
  localparam longint EST_MAX     = (longint'(1) <<< (23 + FRAC)) - 1;
  localparam longint EST_MIN     = -(longint'(1) <<< (23 + FRAC));
  localparam int     STALL_LIMIT = 2000;
  localparam int     TAIL_CYCLES = 150;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [CFG_IW-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IW-1:0] REG_UNUSED_B = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } box_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_operation = OP_START;
  logic signed [COORD_W-1:0] in_rect_x = '0;
  logic signed [COORD_W-1:0] in_rect_y = '0;
  logic [SIZE_W-1:0]         in_rect_w = '0;
  logic [SIZE_W-1:0]         in_rect_h = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_est_x;
  logic signed [COORD_W-1:0] out_est_y;
  logic [SIZE_W-1:0]         out_est_w;
  logic [SIZE_W-1:0]         out_est_h;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CFG_AW-1:0]         paddr = '0;
  logic [CFG_DW-1:0]         pwdata = '0;
  logic [CFG_DW-1:0]         prdata;
  logic                      pready;

  logic [31:0] q_noise = PROCESS_NOISE_RST;
  logic [31:0] r_noise = MEASURE_NOISE_RST;
  logic [31:0] init_cov [4] = '{INIT_COV_RST, INIT_COV_RST, INIT_COV_RST, INIT_COV_RST};
  longint      lane_est [4] = '{0, 0, 0, 0};
  logic [31:0] lane_cov [4] = '{0, 0, 0, 0};

  box_t pending_boxes [$];
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  bit   calm = 1'b0;

  box_kalman_smoother_unit #(
    .LANES(LANES),
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_rect_x(in_rect_x),
    .in_rect_y(in_rect_y),
    .in_rect_w(in_rect_w),
    .in_rect_h(in_rect_h),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_est_x(out_est_x),
    .out_est_y(out_est_y),
    .out_est_w(out_est_w),
    .out_est_h(out_est_h),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void correct_lane(input int lane, input longint z);
    longint unsigned p, den, gain, mag, delta;
    longint          diff, xe;
    p = 64'(lane_cov[lane]) + 64'(q_noise);
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    den = p + 64'(r_noise);
    gain = (den != 0) ? (p << FRAC) / den : 0;
    if (gain > ONE_Q - 1) gain = ONE_Q - 1;
    xe = lane_est[lane];
    diff = z * ONE_Q - xe;
    mag = (diff < 0) ? -diff : diff;
    delta = gain * (mag >> FRAC) + ((gain * (mag & (ONE_Q - 1))) >> FRAC);
    xe = (diff < 0) ? xe - longint'(delta) : xe + longint'(delta);
    lane_est[lane] = clip(xe, EST_MIN, EST_MAX);
    lane_cov[lane] = 32'((p * (ONE_Q - gain)) >> FRAC);
  endfunction

  function automatic box_t smooth_box(input logic op, input logic signed [15:0] x,
                                      input logic signed [15:0] y, input logic [14:0] w,
                                      input logic [14:0] h);
    longint z [4];
    longint whole [4];
    box_t   r;
    int     i;
    z[0] = longint'(x);
    z[1] = longint'(y);
    z[2] = longint'(w);
    z[3] = longint'(h);
    for (i = 0; i < 4; i++) begin
      if (op == OP_START) begin
        lane_est[i] = z[i] * ONE_Q;
        lane_cov[i] = init_cov[i];
      end else begin
        correct_lane(i, z[i]);
      end
      whole[i] = (lane_est[i] < 0) ? -((-lane_est[i]) >>> FRAC) : (lane_est[i] >>> FRAC);
    end
    r.x = 16'(clip(whole[0], -32768, 32767));
    r.y = 16'(clip(whole[1], -32768, 32767));
    r.w = 15'(clip(whole[2], 0, 32767));
    r.h = 15'(clip(whole[3], 0, 32767));
    return r;
  endfunction

  function automatic void check_field(input string field, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_boxes.push_back(smooth_box(in_operation, in_rect_x, in_rect_y,
                                         in_rect_w, in_rect_h));
  end

  always @(posedge clk) begin : result_check
    box_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_boxes.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual %0d %0d %0d %0d", $time,
                 out_est_x, out_est_y, out_est_w, out_est_h);
        mismatch_count++;
      end else begin
        want = pending_boxes.pop_front();
        check_field("est_x", want.x, out_est_x);
        check_field("est_y", want.y, out_est_y);
        check_field("est_w", want.w, out_est_w);
        check_field("est_h", want.h, out_est_h);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d beats outstanding", $time, pending_boxes.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stall_gen
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_stall <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        hold = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_box(input logic op, input int x, input int y, input int w, input int h);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_rect_x    <= 16'(x);
    in_rect_y    <= 16'(y);
    in_rect_w    <= 15'(w);
    in_rect_h    <= 15'(h);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [31:0] value);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PROCESS_NOISE: q_noise = value;
      REG_MEASURE_NOISE: r_noise = value;
      REG_INIT_COV_X:    init_cov[LANE_X] = value;
      REG_INIT_COV_Y:    init_cov[LANE_Y] = value;
      REG_INIT_COV_W:    init_cov[LANE_W] = value;
      REG_INIT_COV_H:    init_cov[LANE_H] = value;
      default: ;
    endcase
  endtask

  task automatic set_filter(input logic [31:0] q, input logic [31:0] r, input logic [31:0] c0,
                            input logic [31:0] c1, input logic [31:0] c2, input logic [31:0] c3);
    cfg_write(REG_PROCESS_NOISE, q);
    cfg_write(REG_MEASURE_NOISE, r);
    cfg_write(REG_INIT_COV_X, c0);
    cfg_write(REG_INIT_COV_Y, c1);
    cfg_write(REG_INIT_COV_W, c2);
    cfg_write(REG_INIT_COV_H, c3);
  endtask

  task automatic test_update_from_reset();
    send_box(OP_UPDATE, 100, -100, 50, 7);
    send_box(OP_UPDATE, 32767, -32768, 32767, 32767);
  endtask

  task automatic test_field_extremes();
    send_box(OP_START, -32768, 32767, 0, 32767);
    send_box(OP_UPDATE, 32767, -32768, 32767, 0);
    send_box(OP_UPDATE, 0, 0, 0, 0);
    send_box(OP_START, 32767, -32768, 32767, 0);
    send_box(OP_UPDATE, -32768, 32767, 0, 32767);
    send_box(OP_START, 0, 0, 0, 0);
  endtask

  task automatic test_zero_noise();
    set_filter(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_box(OP_START, 10, 20, 30, 40);
    send_box(OP_UPDATE, 1000, -1000, 500, 600);
    cfg_write(REG_PROCESS_NOISE, 32'd65536);
    send_box(OP_UPDATE, -2000, 3000, 32767, 1);
    send_box(OP_UPDATE, 5, -5, 5, 5);
  endtask

  task automatic test_saturated_noise();
    set_filter('1, '1, '1, '1, '1, '1);
    send_box(OP_START, -1, 1, 1, 32766);
    send_box(OP_UPDATE, 32767, -32768, 32767, 0);
    send_box(OP_UPDATE, -32768, 32767, 0, 32767);
    cfg_write(REG_MEASURE_NOISE, 32'd1);
    send_box(OP_UPDATE, 123, -456, 789, 1011);
  endtask

  task automatic test_ignored_register();
    cfg_write(REG_UNUSED_A, $urandom());
    cfg_write(REG_UNUSED_B, $urandom());
    send_box(OP_START, 300, -300, 64, 48);
    send_box(OP_UPDATE, 310, -290, 70, 40);
  endtask

  task automatic run_tracks(input int items, input bit with_pause);
    int sent, len, k, spread, bx, by, bw, bh;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < items) begin
      if (with_pause && !paused && sent >= items / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        bx = int'($urandom_range(0, 65535)) - 32768;
        by = int'($urandom_range(0, 65535)) - 32768;
        bw = $urandom_range(0, 32767);
        bh = $urandom_range(0, 32767);
        spread = $urandom_range(0, 1) ? 4 : 300;
        send_box(OP_START, bx, by, bw, bh);
        sent++;
        len = $urandom_range(1, 12);
        for (k = 0; k < len && sent < items; k++) begin
          bx = int'(clip(bx + int'($urandom_range(0, 2 * spread)) - spread, -32768, 32767));
          by = int'(clip(by + int'($urandom_range(0, 2 * spread)) - spread, -32768, 32767));
          bw = int'(clip(bw + int'($urandom_range(0, 2 * spread)) - spread, 0, 32767));
          bh = int'(clip(bh + int'($urandom_range(0, 2 * spread)) - spread, 0, 32767));
          send_box(OP_UPDATE, bx, by, bw, bh);
          sent++;
        end
      end else begin
        send_box(logic'($urandom_range(0, 1)), int'($urandom_range(0, 65535)) - 32768,
                 int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 32767),
                 $urandom_range(0, 32767));
        sent++;
      end
    end
  endtask

  task automatic test_random_tracks();
    set_filter(PROCESS_NOISE_RST, MEASURE_NOISE_RST, INIT_COV_RST, INIT_COV_RST,
               INIT_COV_RST, INIT_COV_RST);
    run_tracks(300, 1'b0);
    set_filter($urandom_range(0, 32'h10000), $urandom_range(1, 32'h10000),
               $urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000),
               $urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000));
    run_tracks(300, 1'b1);
    set_filter(32'd0, '1, 32'd0, '1, 32'd0, '1);
    run_tracks(250, 1'b0);
    set_filter('1, 32'd1, '1, 32'd0, '1, 32'd0);
    run_tracks(250, 1'b0);
    set_filter($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    run_tracks(300, 1'b0);
    set_filter(PROCESS_NOISE_RST, MEASURE_NOISE_RST, INIT_COV_RST, INIT_COV_RST,
               INIT_COV_RST, INIT_COV_RST);
    calm = 1'b1;
    run_tracks(300, 1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_update_from_reset();
    test_field_extremes();
    test_zero_noise();
    test_saturated_noise();
    test_ignored_register();
    test_random_tracks();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
